[hdl/usmp_pkg.sv]
// package: shared types, constants and tables for the uv sphere mesh point block
package usmp_pkg;

    localparam int GRID_W      = 8;
    localparam int POS_W       = 17;
    localparam int NORM_W      = 16;
    localparam int IDX_W       = 16;
    localparam int ANG_W       = 32;
    localparam int CW          = 34;
    localparam int ATAN_N      = 24;
    localparam int RECIP_W     = 41;
    localparam int RECIP_SH    = 40;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int POS_LIMIT   = 65535;
    localparam int NORM_LIMIT  = 16384;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_SECTORS = 2'd1;
    localparam logic [1:0] REG_STACKS  = 2'd2;

    typedef struct packed {
        logic              pv;
        logic              cv;
        logic [ANG_W-1:0]  phi;
        logic [ANG_W-1:0]  theta;
        logic [15:0]       radius;
        logic [IDX_W-1:0]  tl;
        logic [IDX_W-1:0]  bl;
    } item_t;

    function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] k);
        logic [ANG_W-1:0] r;
        begin
            case (k)
                5'd0: r = 32'h20000000;   5'd1: r = 32'h12E4051E;
                5'd2: r = 32'h09FB385B;   5'd3: r = 32'h051111D4;
                5'd4: r = 32'h028B0D43;   5'd5: r = 32'h0145D7E1;
                5'd6: r = 32'h00A2F61E;   5'd7: r = 32'h00517C55;
                5'd8: r = 32'h0028BE53;   5'd9: r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

[hdl/usmp_recip.sv]
// module: reciprocal of a sector or stack count, recomputed after reset or a config write
module usmp_recip (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [usmp_pkg::GRID_W-1:0] divisor,
    output logic                       busy,
    output logic [usmp_pkg::RECIP_W-1:0] quotient
);
    import usmp_pkg::*;

    // restoring division of 2^RECIP_SH by divisor, one bit a cycle
    localparam int G = GRID_W;
    localparam int QW = RECIP_SH + 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [G:0]                 rem_reg, rem_next;
    logic [QW-1:0]              q_reg, q_next;
    logic [QW-1:0]              num_reg, num_next;
    logic [G:0]                 shifted;

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        num_next = num_reg;
        shifted  = {rem_reg[G-1:0], num_reg[QW-1]};
        if (start)
        begin
            cnt_next = CNT_W'(QW);
            rem_next = '0;
            q_next   = '0;
            num_next = QW'(1) << RECIP_SH;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[QW-2:0], 1'b0};
            if (divisor != '0 && shifted >= {1'b0, divisor})
            begin
                rem_next = shifted - {1'b0, divisor};
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        num_reg <= num_next;
    end

    assign busy     = (cnt_reg != '0) || start;
    assign quotient = RECIP_W'(q_reg);

endmodule

[hdl/usmp_front.sv]
// module: front end, range checks, angle and cell index computation
module usmp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    stack_index,
    input  logic [7:0]                    sector_index,
    input  logic [15:0]                   radius,
    input  logic [7:0]                    sectors_cfg,
    input  logic [7:0]                    stacks_cfg,
    input  logic [usmp_pkg::RECIP_W-1:0]  recip_stk,
    input  logic [usmp_pkg::RECIP_W-1:0]  recip_sec,
    input  logic                          hold,
    output logic                          q_valid,
    input  logic                          q_ready,
    output usmp_pkg::item_t               q_item
);
    import usmp_pkg::*;

    localparam int G = GRID_W;
    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    // stage 1: masked indices and products i*recip, j*recip
    logic                v1_reg;
    logic                pv1_reg, cv1_reg;
    logic [G-1:0]        i1_reg, j1_reg, stk1_reg, sec1_reg;
    logic [G+RECIP_W-1:0] pi1_reg, pj1_reg;
    logic [15:0]         rad1_reg;
    logic [IDX_W-1:0]    tl1_reg;

    logic [G-1:0] i_m, j_m, stk_m, sec_m;
    logic pv_c, cv_c, adv;

    // queue
    item_t            mem_reg [DEPTH];
    logic [PW:0]      wp_reg, rp_reg;
    logic [PW:0]      cnt;
    logic             full;

    assign i_m   = stack_index[G-1:0];
    assign j_m   = sector_index[G-1:0];
    assign stk_m = stacks_cfg[G-1:0];
    assign sec_m = sectors_cfg[G-1:0];
    assign pv_c  = stk_m != '0 && sec_m != '0 && i_m <= stk_m && j_m <= sec_m;
    assign cv_c  = pv_c && i_m < stk_m && j_m < sec_m;

    assign cnt  = wp_reg - rp_reg;
    // two items may be in flight past the queue head check
    assign full = cnt >= (PW+1)'(DEPTH - 1);
    assign in_ready = !full && !hold;
    assign adv = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= adv;
    end

    always_ff @(posedge clk)
    begin
        pv1_reg  <= pv_c;
        cv1_reg  <= cv_c;
        i1_reg   <= i_m;
        j1_reg   <= j_m;
        stk1_reg <= stk_m;
        sec1_reg <= sec_m;
        rad1_reg <= radius;
        pi1_reg  <= (G+RECIP_W)'(i_m) * (G+RECIP_W)'(recip_stk);
        pj1_reg  <= (G+RECIP_W)'(j_m) * (G+RECIP_W)'(recip_sec);
        tl1_reg  <= IDX_W'(i_m) * IDX_W'({1'b0, sec_m} + 1'b1) + IDX_W'(j_m);
    end

    // stage 2: quotient correction and angle formation
    // floor(n*2^32/d): estimate from reciprocal, then one correction step
    logic [ANG_W+G:0]   qi_est, qj_est;
    logic [ANG_W+2*G+1:0] ri, rj;
    logic [ANG_W+G:0]   qi, qj;
    logic [ANG_W-1:0]   phi_c, theta_c;
    item_t              it_c;

    always_comb
    begin
        qi_est = (ANG_W+G+1)'(pi1_reg >> (RECIP_SH - ANG_W));
        qj_est = (ANG_W+G+1)'(pj1_reg >> (RECIP_SH - ANG_W));
        ri = ((ANG_W+2*G+2)'(i1_reg) << 32)
             - (ANG_W+2*G+2)'(qi_est) * (ANG_W+2*G+2)'(stk1_reg);
        rj = ((ANG_W+2*G+2)'(j1_reg) << 32)
             - (ANG_W+2*G+2)'(qj_est) * (ANG_W+2*G+2)'(sec1_reg);
        qi = qi_est;
        qj = qj_est;
        if (ri >= (ANG_W+2*G+2)'(stk1_reg) && stk1_reg != '0)
            qi = qi_est + 1'b1;
        if (rj >= (ANG_W+2*G+2)'(sec1_reg) && sec1_reg != '0)
            qj = qj_est + 1'b1;
        // i*2^31/stacks = floor(i*2^32/stacks) >> 1
        phi_c   = 32'h40000000 - ANG_W'(qi >> 1);
        theta_c = ANG_W'(qj);
        it_c.pv     = pv1_reg;
        it_c.cv     = cv1_reg;
        it_c.phi    = phi_c;
        it_c.theta  = theta_c;
        it_c.radius = rad1_reg;
        it_c.tl     = cv1_reg ? tl1_reg : '0;
        it_c.bl     = cv1_reg ? tl1_reg + IDX_W'(sec1_reg) + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (v1_reg)
                wp_reg <= wp_reg + 1'b1;
            if (q_valid && q_ready)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            mem_reg[wp_reg[PW-1:0]] <= it_c;
    end

    assign q_valid = cnt != '0;
    assign q_item  = mem_reg[rp_reg[PW-1:0]];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= (PW+1)'(DEPTH))
        else $error("front queue overflow");
    a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> v1_reg)
        else $error("accepted transaction lost");
    a_cell_implies_point: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && cv1_reg |-> pv1_reg)
        else $error("cell without point");
`endif

endmodule

[hdl/usmp_back.sv]
// module: back end, pipelined cordic pair, products, rounding and output skid
module usmp_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  usmp_pkg::item_t     q_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                busy,
    output logic signed [usmp_pkg::POS_W-1:0]  pos_x,
    output logic signed [usmp_pkg::POS_W-1:0]  pos_y,
    output logic signed [usmp_pkg::POS_W-1:0]  pos_z,
    output logic signed [usmp_pkg::NORM_W-1:0] normal_x,
    output logic signed [usmp_pkg::NORM_W-1:0] normal_y,
    output logic signed [usmp_pkg::NORM_W-1:0] normal_z,
    output logic                point_valid,
    output logic                cell_valid,
    output logic [usmp_pkg::IDX_W-1:0] idx_top_left,
    output logic [usmp_pkg::IDX_W-1:0] idx_bottom_left,
    output logic [usmp_pkg::IDX_W-1:0] idx_top_right,
    output logic [usmp_pkg::IDX_W-1:0] idx_bottom_right
);
    import usmp_pkg::*;

    localparam int NS = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam int LAT = NS + 4;
    localparam int SKID = LAT + 2;
    localparam int CNT_W = $clog2(SKID + 1);

    // whole pipeline advances together; credit count bounds the output fifo
    logic [CNT_W-1:0] credit_reg;
    logic take;
    logic pop;

    // cordic pipeline arrays, one entry per stage
    logic signed [CW-1:0] xp_reg [NS+1];
    logic signed [CW-1:0] yp_reg [NS+1];
    logic signed [CW-1:0] zp_reg [NS+1];
    logic signed [CW-1:0] xt_reg [NS+1];
    logic signed [CW-1:0] yt_reg [NS+1];
    logic signed [CW-1:0] zt_reg [NS+1];
    logic                 vs_reg [NS+1];
    item_t                is_reg [NS+1];
    logic                 fp_reg [NS+1];
    logic                 ft_reg [NS+1];

    assign take = q_valid && credit_reg < CNT_W'(SKID);
    assign q_ready = take;

    function automatic logic signed [CW-1:0] ang_to_z(input logic [ANG_W-1:0] a,
                                                      output logic flip);
        logic [ANG_W-1:0] t;
        logic [ANG_W-1:0] b;
        begin
            t = a + 32'h40000000;
            flip = t[ANG_W-1];
            b = flip ? a + 32'h80000000 : a;
            return CW'($signed(b));
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
                vs_reg[s] <= 1'b0;
        end
        else
        begin
            vs_reg[0] <= take;
            for (int s = 1; s <= NS; s++)
                vs_reg[s] <= vs_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic fa, fb;
        xp_reg[0] <= CORDIC_GAIN;
        yp_reg[0] <= '0;
        zp_reg[0] <= ang_to_z(q_item.phi, fa);
        fp_reg[0] <= fa;
        xt_reg[0] <= CORDIC_GAIN;
        yt_reg[0] <= '0;
        zt_reg[0] <= ang_to_z(q_item.theta, fb);
        ft_reg[0] <= fb;
        is_reg[0] <= q_item;
        for (int s = 1; s <= NS; s++)
        begin
            if (!zp_reg[s-1][CW-1])
            begin
                xp_reg[s] <= xp_reg[s-1] - (yp_reg[s-1] >>> (s-1));
                yp_reg[s] <= yp_reg[s-1] + (xp_reg[s-1] >>> (s-1));
                zp_reg[s] <= zp_reg[s-1] - CW'(atan_lut(5'(s-1)));
            end
            else
            begin
                xp_reg[s] <= xp_reg[s-1] + (yp_reg[s-1] >>> (s-1));
                yp_reg[s] <= yp_reg[s-1] - (xp_reg[s-1] >>> (s-1));
                zp_reg[s] <= zp_reg[s-1] + CW'(atan_lut(5'(s-1)));
            end
            if (!zt_reg[s-1][CW-1])
            begin
                xt_reg[s] <= xt_reg[s-1] - (yt_reg[s-1] >>> (s-1));
                yt_reg[s] <= yt_reg[s-1] + (xt_reg[s-1] >>> (s-1));
                zt_reg[s] <= zt_reg[s-1] - CW'(atan_lut(5'(s-1)));
            end
            else
            begin
                xt_reg[s] <= xt_reg[s-1] + (yt_reg[s-1] >>> (s-1));
                yt_reg[s] <= yt_reg[s-1] - (xt_reg[s-1] >>> (s-1));
                zt_reg[s] <= zt_reg[s-1] + CW'(atan_lut(5'(s-1)));
            end
            fp_reg[s] <= fp_reg[s-1];
            ft_reg[s] <= ft_reg[s-1];
            is_reg[s] <= is_reg[s-1];
        end
    end

    // stage a: apply flips
    logic signed [CW-1:0] cp_a_reg, sp_a_reg, ct_a_reg, st_a_reg;
    logic                 va_reg;
    item_t                ia_reg;
    // stage b: radius products, normal products, rounded theta terms
    logic signed [CW+17:0]  rcp_b_reg, rsp_b_reg;
    logic signed [2*CW-1:0] nx_b_reg, nz_b_reg;
    logic signed [CW-1:0]   sp_b_reg;
    logic signed [CW-10:0]  ct10_b_reg, st10_b_reg;
    logic                   vb_reg;
    item_t                  ib_reg;
    // stage c: xz products
    logic signed [63:0]     px_c_reg, pz_c_reg;
    logic signed [CW+17:0]  rsp_c_reg;
    logic signed [2*CW-1:0] nx_c_reg, nz_c_reg;
    logic signed [CW-1:0]   sp_c_reg;
    logic                   vc_reg;
    item_t                  ic_reg;
    logic signed [CW+1:0]   xz_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= vs_reg[NS];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int k);
        logic signed [63:0] t;
        begin
            t = v + (64'sd1 <<< (k - 1));
            return t >>> k;
        end
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
        begin
            if (v > lim)
                return lim;
            else if (v < -lim)
                return -lim;
            else
                return v;
        end
    endfunction

    always_comb
    begin
        xz_c = (CW+2)'(rsh(64'(rcp_b_reg), 16));
    end

    always_ff @(posedge clk)
    begin
        cp_a_reg <= fp_reg[NS] ? -xp_reg[NS] : xp_reg[NS];
        sp_a_reg <= fp_reg[NS] ? -yp_reg[NS] : yp_reg[NS];
        ct_a_reg <= ft_reg[NS] ? -xt_reg[NS] : xt_reg[NS];
        st_a_reg <= ft_reg[NS] ? -yt_reg[NS] : yt_reg[NS];
        ia_reg   <= is_reg[NS];

        rcp_b_reg  <= $signed({1'b0, ia_reg.radius}) * cp_a_reg;
        rsp_b_reg  <= $signed({1'b0, ia_reg.radius}) * sp_a_reg;
        nx_b_reg   <= cp_a_reg * ct_a_reg;
        nz_b_reg   <= cp_a_reg * st_a_reg;
        sp_b_reg   <= sp_a_reg;
        ct10_b_reg <= (CW-9)'(rsh(64'(ct_a_reg), 10));
        st10_b_reg <= (CW-9)'(rsh(64'(st_a_reg), 10));
        ib_reg     <= ia_reg;

        px_c_reg  <= 64'(xz_c * ct10_b_reg);
        pz_c_reg  <= 64'(xz_c * st10_b_reg);
        rsp_c_reg <= rsp_b_reg;
        nx_c_reg  <= nx_b_reg;
        nz_c_reg  <= nz_b_reg;
        sp_c_reg  <= sp_b_reg;
        ic_reg    <= ib_reg;
    end

    // stage d: round, saturate, zero outside grid, then output fifo
    typedef struct packed {
        logic signed [POS_W-1:0]  px, py, pz;
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic                     pv, cv;
        logic [IDX_W-1:0]         tl, bl;
    } res_t;

    res_t res_d;
    always_comb
    begin
        res_d.pv = ic_reg.pv;
        res_d.cv = ic_reg.cv;
        res_d.tl = ic_reg.tl;
        res_d.bl = ic_reg.bl;
        if (ic_reg.pv)
        begin
            res_d.px = POS_W'(sat(rsh(px_c_reg, 34), 64'(POS_LIMIT)));
            res_d.pz = POS_W'(sat(rsh(pz_c_reg, 34), 64'(POS_LIMIT)));
            res_d.py = POS_W'(sat(rsh(64'(rsp_c_reg), 30), 64'(POS_LIMIT)));
            res_d.nx = NORM_W'(sat(rsh(64'(nx_c_reg), 46), 64'(NORM_LIMIT)));
            res_d.nz = NORM_W'(sat(rsh(64'(nz_c_reg), 46), 64'(NORM_LIMIT)));
            res_d.ny = NORM_W'(sat(rsh(64'(sp_c_reg), 16), 64'(NORM_LIMIT)));
        end
        else
        begin
            res_d.px = '0;
            res_d.py = '0;
            res_d.pz = '0;
            res_d.nx = '0;
            res_d.ny = '0;
            res_d.nz = '0;
        end
    end

    localparam int FD = 1 << $clog2(SKID);
    localparam int FW = $clog2(FD);
    res_t           fifo_reg [FD];
    logic [FW:0]    fwp_reg, frp_reg;
    res_t           head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwp_reg    <= '0;
            frp_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (vc_reg)
                fwp_reg <= fwp_reg + 1'b1;
            if (pop)
                frp_reg <= frp_reg + 1'b1;
            credit_reg <= credit_reg + CNT_W'(take) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (vc_reg)
            fifo_reg[fwp_reg[FW-1:0]] <= res_d;
    end

    assign head      = fifo_reg[frp_reg[FW-1:0]];
    assign out_valid = fwp_reg != frp_reg;
    assign pop       = out_valid && out_ready;
    assign busy      = credit_reg != '0;

    assign pos_x            = head.px;
    assign pos_y            = head.py;
    assign pos_z            = head.pz;
    assign normal_x         = head.nx;
    assign normal_y         = head.ny;
    assign normal_z         = head.nz;
    assign point_valid      = head.pv;
    assign cell_valid       = head.cv;
    assign idx_top_left     = head.cv ? head.tl : '0;
    assign idx_bottom_left  = head.cv ? head.bl : '0;
    assign idx_top_right    = head.cv ? head.tl + 1'b1 : '0;
    assign idx_bottom_right = head.cv ? head.bl + 1'b1 : '0;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CNT_W'(SKID))
        else $error("back end credit overrun");
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fwp_reg - frp_reg) <= (FW+1)'(SKID))
        else $error("output fifo overflow");
    a_out_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_valid |-> point_valid)
        else $error("cell flagged on point outside grid");
`endif

endmodule

[hdl/uv_sphere_mesh_point.sv]
// top level: uv sphere mesh point generator
// throughput: one transaction per cycle, set by the pipelined cordic pair, while the
// input is not held for a reciprocal update and the output fifo is not backed up
// after a sector or stack count write the input is held until the reciprocal units finish
// reset: asynchronous active low, registers return to radius 768, 20 sectors, 15 stacks
module uv_sphere_mesh_point #(
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           stack_index,
    input  logic [7:0]           sector_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [16:0]   pos_x,
    output logic signed [16:0]   pos_y,
    output logic signed [16:0]   pos_z,
    output logic signed [15:0]   normal_x,
    output logic signed [15:0]   normal_y,
    output logic signed [15:0]   normal_z,
    output logic                 point_valid,
    output logic                 cell_valid,
    output logic [15:0]          idx_top_left,
    output logic [15:0]          idx_bottom_left,
    output logic [15:0]          idx_top_right,
    output logic [15:0]          idx_bottom_right
);
    import usmp_pkg::*;

    logic [15:0] radius_reg;
    logic [7:0]  sectors_reg, stacks_reg;
    logic        start_sec_reg, start_stk_reg;
    logic        init_reg;
    logic        busy_sec, busy_stk, back_busy;
    logic [RECIP_W-1:0] rq_sec, rq_stk;
    logic        q_valid, q_ready;
    item_t       q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 16'd768;
            sectors_reg   <= 8'd20;
            stacks_reg    <= 8'd15;
            init_reg      <= 1'b1;
            start_sec_reg <= 1'b0;
            start_stk_reg <= 1'b0;
        end
        else
        begin
            init_reg      <= 1'b0;
            start_sec_reg <= init_reg || (cfg_we && cfg_index == REG_SECTORS);
            start_stk_reg <= init_reg || (cfg_we && cfg_index == REG_STACKS);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIUS:  radius_reg  <= cfg_data;
                    REG_SECTORS: sectors_reg <= cfg_data[7:0];
                    REG_STACKS:  stacks_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    usmp_recip u_recip_sec (
        .clk(clk), .rst_n(rst_n), .start(start_sec_reg),
        .divisor(sectors_reg[GRID_W-1:0]),
        .busy(busy_sec), .quotient(rq_sec)
    );

    usmp_recip u_recip_stk (
        .clk(clk), .rst_n(rst_n), .start(start_stk_reg),
        .divisor(stacks_reg[GRID_W-1:0]),
        .busy(busy_stk), .quotient(rq_stk)
    );

    usmp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .stack_index(stack_index), .sector_index(sector_index),
        .radius(radius_reg), .sectors_cfg(sectors_reg), .stacks_cfg(stacks_reg),
        .recip_stk(rq_stk), .recip_sec(rq_sec),
        .hold(busy_sec || busy_stk || init_reg
              || start_sec_reg || start_stk_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    usmp_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .busy(back_busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .point_valid(point_valid), .cell_valid(cell_valid),
        .idx_top_left(idx_top_left), .idx_bottom_left(idx_bottom_left),
        .idx_top_right(idx_top_right), .idx_bottom_right(idx_bottom_right)
    );

`ifndef SYNTHESIS
    a_hold_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_SECTORS || cfg_index == REG_STACKS) |=> !in_ready)
        else $error("input open while reciprocal is stale");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> back_busy)
        else $error("result shown with no transaction in flight");
    a_hold_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_sec_reg |=> busy_sec)
        else $error("reciprocal unit did not start");
`endif

endmodule

[sim/usmp_checker.sv]
// checker: watches both channels, predicts each mesh point result and compares
`timescale 1ns / 100ps
module usmp_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          stack_index,
    input  logic [7:0]          sector_index,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [16:0]  pos_x,
    input  logic signed [16:0]  pos_y,
    input  logic signed [16:0]  pos_z,
    input  logic signed [15:0]  normal_x,
    input  logic signed [15:0]  normal_y,
    input  logic signed [15:0]  normal_z,
    input  logic                point_valid,
    input  logic                cell_valid,
    input  logic [15:0]         idx_top_left,
    input  logic [15:0]         idx_bottom_left,
    input  logic [15:0]         idx_top_right,
    input  logic [15:0]         idx_bottom_right,
    output int                  fail_count,
    output int                  pending_points
);
    import usmp_pkg::*;

    localparam int STEPS = 16;

    typedef struct packed {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               pv;
        logic               cv;
        logic [15:0]        tl;
        logic [15:0]        bl;
        logic [15:0]        tr;
        logic [15:0]        br;
    } mesh_point_t;

    mesh_point_t expected_points[$];
    logic [15:0] radius;
    logic [7:0]  sectors;
    logic [7:0]  stacks;

    function automatic longint floor_sh(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_sh(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        logic   flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [31:0] a;
        flip = ang[31] ^ ang[30];
        a = flip ? ang + 32'h80000000 : ang;
        x = 652032874;
        y = 0;
        z = longint'($signed(a));
        for (int k = 0; k < STEPS; k++)
        begin
            dx = floor_sh(y, k);
            dy = floor_sh(x, k);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_lut(k[4:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_lut(k[4:0]));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_point(input logic [7:0] i, input logic [7:0] j,
                                 output mesh_point_t p);
        logic [31:0] phi;
        logic [31:0] theta;
        longint cp, sp, ct, st, xz, r;
        logic [31:0] tl32;
        logic [31:0] bl32;
        p = '0;
        p.pv = stacks != 0 && sectors != 0 && i <= stacks && j <= sectors;
        p.cv = p.pv && i < stacks && j < sectors;
        if (p.pv)
        begin
            phi = 32'h40000000 - 32'((64'(i) << 31) / stacks);
            theta = 32'((64'(j) << 32) / sectors);
            rotate(phi, cp, sp);
            rotate(theta, ct, st);
            r = longint'(radius);
            xz = round_sh(r * cp, 16);
            p.px = 17'(clamp(round_sh(xz * round_sh(ct, 10), 34), 65535));
            p.py = 17'(clamp(round_sh(r * sp, 30), 65535));
            p.pz = 17'(clamp(round_sh(xz * round_sh(st, 10), 34), 65535));
            p.nx = 16'(clamp(round_sh(cp * ct, 46), 16384));
            p.ny = 16'(clamp(round_sh(sp, 16), 16384));
            p.nz = 16'(clamp(round_sh(cp * st, 46), 16384));
        end
        if (p.cv)
        begin
            tl32 = 32'(i) * (32'(sectors) + 1) + 32'(j);
            bl32 = tl32 + 32'(sectors) + 1;
            p.tl = tl32[15:0];
            p.bl = bl32[15:0];
            p.tr = 16'(tl32 + 1);
            p.br = 16'(bl32 + 1);
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_points = expected_points.size();

    always @(posedge clk or negedge rst_n)
    begin
        mesh_point_t p;
        mesh_point_t e;
        if (!rst_n)
        begin
            radius <= 16'd768;
            sectors <= 8'd20;
            stacks <= 8'd15;
            expected_points.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_point(stack_index, sector_index, p);
                expected_points.insert(expected_points.size(), p);
            end
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                    report("unexpected transaction", 0, 0);
                else
                begin
                    e = expected_points.pop_front();
                    if (pos_x !== e.px) report("pos_x", pos_x, e.px);
                    if (pos_y !== e.py) report("pos_y", pos_y, e.py);
                    if (pos_z !== e.pz) report("pos_z", pos_z, e.pz);
                    if (normal_x !== e.nx) report("normal_x", normal_x, e.nx);
                    if (normal_y !== e.ny) report("normal_y", normal_y, e.ny);
                    if (normal_z !== e.nz) report("normal_z", normal_z, e.nz);
                    if (point_valid !== e.pv) report("point_valid", point_valid, e.pv);
                    if (cell_valid !== e.cv) report("cell_valid", cell_valid, e.cv);
                    if (idx_top_left !== e.tl) report("idx_top_left", idx_top_left, e.tl);
                    if (idx_bottom_left !== e.bl)
                        report("idx_bottom_left", idx_bottom_left, e.bl);
                    if (idx_top_right !== e.tr)
                        report("idx_top_right", idx_top_right, e.tr);
                    if (idx_bottom_right !== e.br)
                        report("idx_bottom_right", idx_bottom_right, e.br);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_RADIUS)
                    radius <= cfg_data;
                else if (cfg_index == REG_SECTORS)
                    sectors <= cfg_data[7:0];
                else if (cfg_index == REG_STACKS)
                    stacks <= cfg_data[7:0];
            end
        end
    end

endmodule

[sim/testbench.sv]
// testbench top: stimulus, register phases and verdict for the mesh point block
`timescale 1ns / 100ps
module testbench;
    import usmp_pkg::*;

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_RADIUS;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] stack_index = '0;
    logic [7:0] sector_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic point_valid, cell_valid;
    logic [15:0] idx_top_left, idx_bottom_left, idx_top_right, idx_bottom_right;
    int fail_count;
    int pending_points;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    logic [7:0] cur_stacks = 8'd15;
    logic [7:0] cur_sectors = 8'd20;

    always #10 clk = ~clk;

    uv_sphere_mesh_point dut (.*);
    usmp_checker checker_i (.*);

    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic send_point(input logic [7:0] i, input logic [7:0] j);
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        stack_index <= i;
        sector_index <= j;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_points != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_STACKS)
            cur_stacks = val[7:0];
        if (idx == REG_SECTORS)
            cur_sectors = val[7:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_points(input int n);
        logic [7:0] i;
        logic [7:0] j;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 8)
            begin
                i = 8'($urandom_range(cur_stacks));
                j = 8'($urandom_range(cur_sectors));
            end
            else
            begin
                i = 8'($urandom);
                j = 8'($urandom);
            end
            send_point(i, j);
        end
    endtask

    initial
    begin
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // poles, equator, seam, edge of grid and beyond at reset settings
        send_point(8'd0, 8'd0);
        send_point(8'd15, 8'd0);
        send_point(8'd7, 8'd5);
        send_point(8'd15, 8'd20);
        send_point(8'd14, 8'd19);
        send_point(8'd16, 8'd3);
        send_point(8'd3, 8'd21);
        send_point(8'd255, 8'd255);
        send_point(8'hAA, 8'h55);
        send_point(8'h55, 8'hAA);
        send_point(8'd5, 8'd10);
        drain();
        write_reg(REG_RADIUS, 16'd0);
        drain();
        send_point(8'd4, 8'd4);
        send_point(8'd0, 8'd0);
        drain();
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_SECTORS, 16'd255);
        write_reg(REG_STACKS, 16'd255);
        drain();
        send_point(8'd0, 8'd0);
        send_point(8'd255, 8'd255);
        send_point(8'd254, 8'd254);
        send_point(8'd128, 8'd64);
        random_points(300);
        drain();
        write_reg(REG_RADIUS, 16'd1);
        write_reg(REG_SECTORS, 16'd3);
        write_reg(REG_STACKS, 16'd2);
        drain();
        calm = 1'b1;
        random_points(200);
        calm = 1'b0;
        drain();
        write_reg(REG_SECTORS, 16'd0);
        drain();
        send_point(8'd0, 8'd0);
        send_point(8'd1, 8'd2);
        drain();
        write_reg(REG_RADIUS, 16'd300);
        write_reg(REG_SECTORS, 16'd7);
        write_reg(REG_STACKS, 16'd0);
        drain();
        send_point(8'd0, 8'd0);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_RADIUS, 16'($urandom_range(65535, 1)));
            write_reg(REG_SECTORS, 16'($urandom_range(255, 3)));
            write_reg(REG_STACKS, 16'($urandom_range(255, 2)));
            drain();
            random_points(230);
            drain();
        end
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
